### rtl/xpf_pkg.sv
// shared types and constants for the payload fragmenter
package xpf_pkg;

  localparam int unsigned FRAME_LEN_W = 24;
  localparam int unsigned PAYLOAD_W   = 16;
  localparam int unsigned IDENT_W     = 24;
  localparam int unsigned HDR_BYTES   = 6;
  localparam int unsigned BEAT_W      = $clog2(HDR_BYTES + 1);
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam logic [CFG_IDX_W-1:0] REG_STREAM_IDENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = CFG_IDX_W'(1);
  localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD_RST  = PAYLOAD_W'(1394);

  typedef enum logic [1:0] {
    FRAG_WHOLE  = 2'd0,
    FRAG_FIRST  = 2'd1,
    FRAG_MIDDLE = 2'd2,
    FRAG_LAST   = 2'd3
  } frag_e;

  // per-item fields the output side needs to emit the results of one item (the stream ident comes from its register)
  typedef struct packed {
    logic [7:0]           data;
    logic                 pend;
    logic                 hdr;
    frag_e                frag;
    logic [PAYLOAD_W-1:0] dlen;
  } xpf_desc_t;

  function automatic logic [7:0] type_byte(frag_e frag);
    return {frag, 5'b0, (frag == FRAG_WHOLE)};
  endfunction

endpackage

### rtl/xiph_payload_fragmenter.sv
// top level: configuration registers, item register and header/data byte sequencer
// Cuts a byte stream of frames into packets of at most max_payload data bytes, each opened by a
// six-byte header (stream ident, type byte, big-endian data length). An item that carries an
// ordinary data byte yields one result and, while the output is not stalled, the block takes one
// item per cycle. An item that opens a packet yields seven results (six header bytes, then the
// data byte); the single output register holds the input stalled until the data byte leaves. The
// next item is taken in the same cycle as the last result of the previous one leaves.
// Configuration writes are always ready; write them only while no item is in flight.
module xiph_payload_fragmenter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [xpf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [xpf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic [23:0]                   frame_len_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          packet_end_o,
  output logic                          run_last_o
);
  import xpf_pkg::*;

  logic [IDENT_W-1:0]   stream_ident_q;
  logic [PAYLOAD_W-1:0] max_payload_q;

  xpf_desc_t            desc_d, desc_q;
  logic                 valid_q;
  logic [BEAT_W-1:0]    beat_q;
  logic                 in_accept;
  logic                 last_beat;
  logic                 out_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_ident_q <= '0;
      max_payload_q  <= MAX_PAYLOAD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_STREAM_IDENT: stream_ident_q <= cfg_data_i[IDENT_W-1:0];
        REG_MAX_PAYLOAD:  max_payload_q  <= cfg_data_i[PAYLOAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign last_beat  = (beat_q == BEAT_W'(HDR_BYTES));
  assign out_take   = valid_q && !out_stall_i;
  assign in_stall_o = valid_q && !(last_beat && !out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  xpf_frame_ctrl u_frame_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .data_byte_i   (data_byte_i),
    .frame_len_i   (frame_len_i),
    .max_payload_i (max_payload_q),
    .desc_o        (desc_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= '0;
    end else if (in_accept) begin
      valid_q <= 1'b1;
      // items without a header go straight to the data beat
      beat_q  <= desc_d.hdr ? '0 : BEAT_W'(HDR_BYTES);
    end else if (out_take) begin
      if (last_beat) begin
        valid_q <= 1'b0;
      end else begin
        beat_q <= beat_q + BEAT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      desc_q <= desc_d;
    end
  end

  always_comb begin
    case (beat_q)
      BEAT_W'(0): out_byte_o = stream_ident_q[23:16];
      BEAT_W'(1): out_byte_o = stream_ident_q[15:8];
      BEAT_W'(2): out_byte_o = stream_ident_q[7:0];
      BEAT_W'(3): out_byte_o = type_byte(desc_q.frag);
      BEAT_W'(4): out_byte_o = desc_q.dlen[15:8];
      BEAT_W'(5): out_byte_o = desc_q.dlen[7:0];
      default:    out_byte_o = desc_q.data;
    endcase
  end

  assign out_valid_o  = valid_q;
  assign packet_end_o = last_beat && desc_q.pend;
  assign run_last_o   = last_beat;

endmodule

### rtl/xpf_frame_ctrl.sv
// frame and packet bookkeeping: decides header, fragment type and data length per item
module xpf_frame_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [7:0]                    data_byte_i,
  input  logic [23:0]                   frame_len_i,
  input  logic [xpf_pkg::PAYLOAD_W-1:0] max_payload_i,
  output xpf_pkg::xpf_desc_t            desc_o
);
  import xpf_pkg::*;

  logic [FRAME_LEN_W-1:0] frame_left_q, frame_left_d;
  logic [PAYLOAD_W-1:0]   packet_left_q, packet_left_d;
  logic                   frag_q, frag_d;
  logic                   sent_q, sent_d;

  logic [PAYLOAD_W-1:0]   mp;
  logic [FRAME_LEN_W-1:0] mp_ext;
  logic [FRAME_LEN_W-1:0] len;
  logic [FRAME_LEN_W-1:0] fl_eff;
  logic [PAYLOAD_W-1:0]   pl_eff;
  logic [PAYLOAD_W-1:0]   pl_start;
  logic [PAYLOAD_W-1:0]   dlen;
  logic                   new_frame;
  logic                   frag_eff;
  logic                   sent_eff;
  logic                   hdr;
  frag_e                  frag;

  always_comb begin
    mp        = (max_payload_i == '0) ? PAYLOAD_W'(1) : max_payload_i;
    mp_ext    = FRAME_LEN_W'(mp);
    len       = FRAME_LEN_W'(frame_len_i);
    if (len == '0) begin
      len = FRAME_LEN_W'(1);
    end
    new_frame = (frame_left_q == '0);
    fl_eff    = new_frame ? len : frame_left_q;
    frag_eff  = new_frame ? (len > mp_ext) : frag_q;
    sent_eff  = new_frame ? 1'b0 : sent_q;
    pl_eff    = new_frame ? '0 : packet_left_q;
    hdr       = (pl_eff == '0);
    dlen      = (fl_eff < mp_ext) ? fl_eff[PAYLOAD_W-1:0] : mp;

    if (!frag_eff) begin
      frag = FRAG_WHOLE;
    end else if (!sent_eff) begin
      frag = FRAG_FIRST;
    end else if (fl_eff > mp_ext) begin
      frag = FRAG_MIDDLE;
    end else begin
      frag = FRAG_LAST;
    end

    pl_start      = hdr ? dlen : pl_eff;
    sent_d        = sent_eff | (hdr & frag_eff);
    frag_d        = frag_eff;
    packet_left_d = pl_start - PAYLOAD_W'(1);
    frame_left_d  = fl_eff - FRAME_LEN_W'(1);

    desc_o.data = data_byte_i;
    desc_o.pend = (pl_start == PAYLOAD_W'(1));
    desc_o.hdr  = hdr;
    desc_o.frag = frag;
    desc_o.dlen = dlen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_left_q  <= '0;
      packet_left_q <= '0;
      frag_q        <= 1'b0;
      sent_q        <= 1'b0;
    end else if (accept_i) begin
      frame_left_q  <= frame_left_d;
      packet_left_q <= packet_left_d;
      frag_q        <= frag_d;
      sent_q        <= sent_d;
    end
  end

endmodule
